// File: sv/mcsg_pkg.sv
package mcsg_pkg;

  localparam int NUM_OUTPUTS = 4;
  localparam logic [7:0] USB_PORT_GROUP = 8'd16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] CLK_MASTER = 2'd0;
  localparam logic [1:0] CLK_SLAVE = 2'd1;
  localparam logic [1:0] CLK_AUTO = 2'd2;

  localparam logic [1:0] REG_CLOCK_MODE = 2'd0;
  localparam logic [1:0] REG_TEMPO_PERIOD = 2'd1;
  localparam logic [1:0] REG_DIVIDER_TABLE = 2'd2;
  localparam logic [1:0] REG_PULSE_WIDTH_TABLE = 2'd3;

  localparam logic [7:0] RT_CLOCK = 8'hf8;
  localparam logic [7:0] RT_START = 8'hfa;
  localparam logic [7:0] RT_CONTINUE = 8'hfb;
  localparam logic [7:0] RT_STOP = 8'hfc;

  localparam logic [31:0] ACC_STEP = 32'd1000000;
  localparam logic [15:0] AUTO_LIMIT = 16'h0fff;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] midi_byte;
    logic [7:0] port;
  } in_item_t;

  typedef struct packed {
    logic       clock_event;
    logic       start_event;
    logic       stop_event;
    logic       continue_event;
    logic       running;
    logic       slave_active;
    logic [3:0] gate_bits;
  } out_item_t;

endpackage

// File: sv/midi_clock_sync_generator.sv
// Timer ticks, realtime bytes and restart requests enter on the input channel;
// each timer tick yields one output transaction with events, run state, slave
// flag and gate bits. Bytes and restarts yield no output transaction.
// A tick that makes a clock event steps through the divider states, since a
// single bit-serial remainder unit checks each output's divider in turn; other
// ticks skip them. Output is registered, so the input is taken again while a
// result waits; a later tick holds in its last cycle until that result is taken.
module midi_clock_sync_generator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcsg_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcsg_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_GATE = 2'd3;
  localparam logic [3:0] USB_GRP_HI = mcsg_pkg::USB_PORT_GROUP[7:4];

  logic [1:0]  state;
  logic [1:0]  clock_mode;
  logic [29:0] tempo_period;
  logic [31:0] divider_table;
  logic [31:0] pulse_width_table;

  logic [15:0] interval_counter;
  logic [15:0] measured_interval;
  logic [15:0] interpolation_delay;
  logic [1:0]  interpolated_sent;
  logic [7:0]  pending_clocks;
  logic        start_pending, stop_pending, continue_pending, run_flag;
  logic [31:0] tempo_accumulator;
  logic [31:0] clock_tick_count;
  logic [15:0] pulse_counters [mcsg_pkg::NUM_OUTPUTS];
  logic [3:0]  gate_register;

  logic [1:0]  out_idx;
  logic        div_start, div_busy, div_hit;
  logic [7:0]  cur_div;
  logic        ev_clock, ev_start, ev_stop, ev_cont, slave;

  logic        accept;
  logic        drop_port;
  logic [15:0] ic_next;
  logic        slave_next;
  logic [15:0] idly_dec;
  logic        interp_fire;
  logic [7:0]  pend_after;
  logic [31:0] acc_add;
  logic        acc_over;
  logic        clock_hit;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign drop_port = (in_data.port[7:4] == USB_GRP_HI) && (in_data.port[3:0] != 4'd0);
  assign div_start = (state == ST_DIV);

  assign cur_div = divider_table[{out_idx, 3'b000} +: 8];

  mcsg_divcheck u_divcheck (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (clock_tick_count),
    .div   (cur_div),
    .busy  (div_busy),
    .hit   (div_hit)
  );

  always_comb begin
    ic_next = (interval_counter != 16'hffff) ? interval_counter + 16'd1 : interval_counter;
    if (clock_mode == mcsg_pkg::CLK_MASTER) begin
      slave_next = 1'b0;
    end else if (clock_mode == mcsg_pkg::CLK_SLAVE) begin
      slave_next = 1'b1;
    end else begin
      slave_next = ic_next < mcsg_pkg::AUTO_LIMIT;
    end
    idly_dec = interpolation_delay - 16'd1;
    interp_fire = (idly_dec == 16'd0) && (interpolated_sent != 2'd3);
    pend_after = pending_clocks + {7'd0, interp_fire};
    acc_add = tempo_accumulator + mcsg_pkg::ACC_STEP;
    acc_over = acc_add > {2'b00, tempo_period};
    clock_hit = (pend_after != 8'd0) ? slave_next : (!slave_next && acc_over);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      clock_mode <= mcsg_pkg::CLK_AUTO;
      tempo_period <= 30'd5208333;
      divider_table <= 32'h04040404;
      pulse_width_table <= 32'h02020202;
      interval_counter <= '0;
      measured_interval <= '0;
      interpolation_delay <= '0;
      interpolated_sent <= '0;
      pending_clocks <= '0;
      start_pending <= 1'b0;
      stop_pending <= 1'b0;
      continue_pending <= 1'b0;
      run_flag <= 1'b0;
      tempo_accumulator <= '0;
      clock_tick_count <= '0;
      gate_register <= '0;
      for (int i = 0; i < mcsg_pkg::NUM_OUTPUTS; i++) begin
        pulse_counters[i] <= '0;
      end
      out_idx <= '0;
    end else begin
      if (out_valid && !out_stall && state != ST_GATE) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          mcsg_pkg::REG_CLOCK_MODE: clock_mode <= cfg_data[1:0];
          mcsg_pkg::REG_TEMPO_PERIOD: tempo_period <= cfg_data[29:0];
          mcsg_pkg::REG_DIVIDER_TABLE: divider_table <= cfg_data;
          mcsg_pkg::REG_PULSE_WIDTH_TABLE: pulse_width_table <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              mcsg_pkg::MODE_TICK: begin
                ev_start <= start_pending;
                ev_stop <= stop_pending;
                ev_cont <= continue_pending;
                start_pending <= 1'b0;
                stop_pending <= 1'b0;
                continue_pending <= 1'b0;
                if (continue_pending) begin
                  run_flag <= 1'b1;
                end else if (stop_pending) begin
                  run_flag <= 1'b0;
                end else if (start_pending) begin
                  run_flag <= 1'b1;
                end
                interval_counter <= ic_next;
                slave <= slave_next;
                interpolation_delay <= interp_fire ? measured_interval >> 2 : idly_dec;
                if (interp_fire) begin
                  interpolated_sent <= interpolated_sent + 2'd1;
                end
                out_idx <= '0;
                pending_clocks <= (pend_after != 8'd0) ? pend_after - 8'd1 : pend_after;
                if (pend_after == 8'd0 && !slave_next) begin
                  tempo_accumulator <= acc_over ? acc_add - {2'b00, tempo_period} : acc_add;
                end
                if (clock_hit) begin
                  ev_clock <= 1'b1;
                  clock_tick_count <= (start_pending ? 32'd0 : clock_tick_count) + 32'd1;
                  state <= ST_DIV;
                end else begin
                  ev_clock <= 1'b0;
                  if (start_pending) begin
                    clock_tick_count <= '0;
                  end
                  state <= ST_GATE;
                end
              end
              mcsg_pkg::MODE_BYTE: begin
                if (!drop_port) begin
                  case (in_data.midi_byte)
                    mcsg_pkg::RT_CLOCK: begin
                      measured_interval <= interval_counter;
                      interval_counter <= '0;
                      pending_clocks <= pending_clocks + 8'd4 - {6'd0, interpolated_sent};
                      interpolated_sent <= '0;
                      interpolation_delay <= interval_counter >> 2;
                    end
                    mcsg_pkg::RT_START: begin
                      start_pending <= 1'b1;
                      if (interval_counter > mcsg_pkg::AUTO_LIMIT) begin
                        interval_counter <= '0;
                      end
                      pending_clocks <= '0;
                      interpolated_sent <= 2'd3;
                    end
                    mcsg_pkg::RT_CONTINUE: continue_pending <= 1'b1;
                    mcsg_pkg::RT_STOP: stop_pending <= 1'b1;
                    default: ;
                  endcase
                end
              end
              mcsg_pkg::MODE_RESTART: start_pending <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (!div_busy) begin
            if (div_hit) begin
              pulse_counters[out_idx] <= {8'd0, pulse_width_table[{out_idx, 3'b000} +: 8]};
            end
            if (out_idx == 2'd3) begin
              state <= ST_GATE;
              out_idx <= '0;
            end else begin
              out_idx <= out_idx + 2'd1;
              state <= ST_DIV;
            end
          end
        end
        ST_GATE: begin
          if (!(out_valid && out_stall)) begin
            if (!run_flag) begin
              gate_register <= '0;
              out_data.gate_bits <= '0;
            end else begin
              for (int i = 0; i < mcsg_pkg::NUM_OUTPUTS; i++) begin
                if (pulse_counters[i] != 16'd0) begin
                  pulse_counters[i] <= pulse_counters[i] - 16'd1;
                  gate_register[i] <= (pulse_counters[i] != 16'd1);
                  out_data.gate_bits[i] <= (pulse_counters[i] != 16'd1);
                end else begin
                  out_data.gate_bits[i] <= gate_register[i];
                end
              end
            end
            out_data.clock_event <= ev_clock;
            out_data.start_event <= ev_start;
            out_data.stop_event <= ev_stop;
            out_data.continue_event <= ev_cont;
            out_data.running <= run_flag;
            out_data.slave_active <= slave;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !accept) else $error("input taken while busy");
  a_gate_stopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.running) |-> (out_data.gate_bits == 4'd0))
    else $error("gate active while stopped");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy) else $error("divider busy in idle");
`endif
endmodule

// File: sv/mcsg_divcheck.sv
module mcsg_divcheck (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] count,
  input  logic [7:0]  div,
  output logic        busy,
  output logic        hit
);
  logic [4:0]  bit_idx;
  logic [31:0] quo_bits;
  logic [8:0]  rem;
  logic [8:0]  shifted;

  assign shifted = {rem[7:0], quo_bits[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      bit_idx <= 5'd0;
      rem <= 9'd0;
      quo_bits <= count;
    end else if (busy) begin
      quo_bits <= {quo_bits[30:0], 1'b0};
      if (shifted >= {1'b0, div}) begin
        rem <= shifted - {1'b0, div};
      end else begin
        rem <= shifted;
      end
      bit_idx <= bit_idx + 5'd1;
      if (bit_idx == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  assign hit = (div != 8'd0) && (rem == 9'd0);
endmodule

// File: tb/midi_clock_sync_generator_tb.sv
`timescale 1ns / 1ps
module midi_clock_sync_generator_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mcsg_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mcsg_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  mcsg_pkg::out_item_t tick_results[$];

  // sync model state
  logic [1:0] m_clock_mode;
  logic [29:0] m_tempo_period;
  logic [31:0] m_dividers;
  logic [31:0] m_widths;
  logic [15:0] m_interval_cnt, m_measured, m_interp_delay;
  logic [1:0] m_interp_sent;
  logic [7:0] m_pending_clocks;
  logic m_start_pend, m_stop_pend, m_cont_pend, m_run;
  logic [31:0] m_tempo_acc, m_tick_count;
  logic [15:0] m_pulse_cnt [mcsg_pkg::NUM_OUTPUTS];
  logic [3:0] m_gates;

  midi_clock_sync_generator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic sync_reset();
    m_clock_mode = mcsg_pkg::CLK_AUTO;
    m_tempo_period = 30'd5208333;
    m_dividers = 32'h04040404;
    m_widths = 32'h02020202;
    m_interval_cnt = '0; m_measured = '0; m_interp_delay = '0;
    m_interp_sent = '0; m_pending_clocks = '0;
    m_start_pend = 0; m_stop_pend = 0; m_cont_pend = 0; m_run = 0;
    m_tempo_acc = '0; m_tick_count = '0;
    for (int n = 0; n < mcsg_pkg::NUM_OUTPUTS; n++) m_pulse_cnt[n] = '0;
    m_gates = '0;
  endtask

  task automatic sync_byte(logic [7:0] b, logic [7:0] p);
    if (p[7:4] == mcsg_pkg::USB_PORT_GROUP[7:4] && p[3:0] != 4'd0) return;
    case (b)
      mcsg_pkg::RT_CLOCK: begin
        m_measured = m_interval_cnt;
        m_interval_cnt = '0;
        m_pending_clocks = m_pending_clocks + 8'd4 - 8'(m_interp_sent);
        m_interp_sent = '0;
        m_interp_delay = m_measured >> 2;
      end
      mcsg_pkg::RT_START: begin
        m_start_pend = 1;
        if (m_interval_cnt > mcsg_pkg::AUTO_LIMIT) m_interval_cnt = '0;
        m_pending_clocks = '0;
        m_interp_sent = 2'd3;
      end
      mcsg_pkg::RT_CONTINUE: m_cont_pend = 1;
      mcsg_pkg::RT_STOP: m_stop_pend = 1;
      default: ;
    endcase
  endtask

  function automatic mcsg_pkg::out_item_t sync_tick();
    mcsg_pkg::out_item_t r;
    logic slave;
    logic [7:0] dv;
    r = '0;
    if (m_interval_cnt != 16'hffff) m_interval_cnt++;
    if (m_clock_mode == mcsg_pkg::CLK_MASTER) slave = 0;
    else if (m_clock_mode == mcsg_pkg::CLK_SLAVE) slave = 1;
    else slave = m_interval_cnt < mcsg_pkg::AUTO_LIMIT;
    m_interp_delay = m_interp_delay - 16'd1;
    if (m_interp_delay == 0 && m_interp_sent < 2'd3) begin
      m_interp_sent++;
      m_pending_clocks++;
      m_interp_delay = m_measured >> 2;
    end
    if (m_start_pend) begin
      m_start_pend = 0; r.start_event = 1; m_run = 1; m_tick_count = '0;
    end
    if (m_stop_pend) begin
      m_stop_pend = 0; r.stop_event = 1; m_run = 0;
    end
    if (m_cont_pend) begin
      m_cont_pend = 0; r.continue_event = 1; m_run = 1;
    end
    if (m_pending_clocks != 0) begin
      m_pending_clocks--;
      if (slave) r.clock_event = 1;
    end else if (!slave) begin
      m_tempo_acc = m_tempo_acc + mcsg_pkg::ACC_STEP;
      if (m_tempo_acc > {2'b00, m_tempo_period}) begin
        m_tempo_acc = m_tempo_acc - {2'b00, m_tempo_period};
        r.clock_event = 1;
      end
    end
    if (r.clock_event) begin
      m_tick_count++;
      for (int n = 0; n < mcsg_pkg::NUM_OUTPUTS; n++) begin
        dv = m_dividers[8*n +: 8];
        if (dv != 0 && (m_tick_count % dv) == 0)
          m_pulse_cnt[n] = {8'd0, m_widths[8*n +: 8]};
      end
    end
    if (!m_run) m_gates = '0;
    else begin
      for (int n = 0; n < mcsg_pkg::NUM_OUTPUTS; n++) begin
        if (m_pulse_cnt[n] > 0) begin
          m_pulse_cnt[n]--;
          m_gates[n] = (m_pulse_cnt[n] != 0);
        end
      end
    end
    r.running = m_run;
    r.slave_active = slave;
    r.gate_bits = m_gates;
    return r;
  endfunction

  task automatic send_item(logic [1:0] mode, logic [7:0] b, logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: mode, midi_byte: b, port: p};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mode == mcsg_pkg::MODE_TICK) tick_results.push_back(sync_tick());
    else if (mode == mcsg_pkg::MODE_BYTE) sync_byte(b, p);
    else if (mode == mcsg_pkg::MODE_RESTART) m_start_pend = 1;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (tick_results.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, out_data);
        errors++;
      end else begin
        mcsg_pkg::out_item_t e;
        e = tick_results.pop_front();
        if (e !== out_data) begin
          $display("%0t: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic drain();
    in_valid <= 1'b0;
    while (tick_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mcsg_pkg::REG_CLOCK_MODE: m_clock_mode = val[1:0];
      mcsg_pkg::REG_TEMPO_PERIOD: m_tempo_period = val[29:0];
      mcsg_pkg::REG_DIVIDER_TABLE: m_dividers = val;
      mcsg_pkg::REG_PULSE_WIDTH_TABLE: m_widths = val;
      default: ;
    endcase
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(mcsg_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_START, 8'h00);
    ticks(3);
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_CLOCK, 8'h10);
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_CLOCK, 8'h1f);
    ticks(2);
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_STOP, 8'hff);
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_CONTINUE, 8'h20);
    send_item(mcsg_pkg::MODE_BYTE, 8'hfe, 8'h00);
    send_item(mcsg_pkg::MODE_BYTE, 8'h00, 8'h00);
    send_item(mcsg_pkg::MODE_NONE, 8'hff, 8'hff);
    ticks(2);
    send_item(mcsg_pkg::MODE_RESTART, 8'h00, 8'h00);
    ticks(3);
  endtask

  task automatic test_master();
    write_reg(mcsg_pkg::REG_CLOCK_MODE, 32'(mcsg_pkg::CLK_MASTER));
    write_reg(mcsg_pkg::REG_TEMPO_PERIOD, 32'd0);
    write_reg(mcsg_pkg::REG_DIVIDER_TABLE, 32'h00ff0103);
    write_reg(mcsg_pkg::REG_PULSE_WIDTH_TABLE, 32'hff000105);
    send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_START, 8'h00);
    ticks(12);
    write_reg(mcsg_pkg::REG_TEMPO_PERIOD, 32'h3fffffff);
    ticks(3);
    write_reg(mcsg_pkg::REG_TEMPO_PERIOD, 32'd2083333);
    write_reg(mcsg_pkg::REG_DIVIDER_TABLE, 32'hffffffff);
    write_reg(mcsg_pkg::REG_PULSE_WIDTH_TABLE, 32'h00000000);
    ticks(10);
  endtask

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) send_item(mcsg_pkg::MODE_TICK, 8'($urandom), 8'($urandom));
      else if (r < 80) send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_CLOCK,
          ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
      else if (r < 95) begin
        case ($urandom_range(3))
          0: send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_START, 8'($urandom_range(15)));
          1: send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_STOP, 8'h00);
          2: send_item(mcsg_pkg::MODE_BYTE, mcsg_pkg::RT_CONTINUE, 8'h10);
          default: send_item(mcsg_pkg::MODE_RESTART, 8'($urandom), 8'($urandom));
        endcase
      end else send_item(2'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random();
    write_reg(mcsg_pkg::REG_CLOCK_MODE, 32'(mcsg_pkg::CLK_AUTO));
    write_reg(mcsg_pkg::REG_DIVIDER_TABLE, 32'h04030201);
    write_reg(mcsg_pkg::REG_PULSE_WIDTH_TABLE, 32'h03020104);
    send_idle_pct = 36; recv_idle_pct = 54;
    random_phase(330);
    write_reg(mcsg_pkg::REG_CLOCK_MODE, 32'(mcsg_pkg::CLK_SLAVE));
    write_reg(mcsg_pkg::REG_DIVIDER_TABLE, $urandom);
    write_reg(mcsg_pkg::REG_PULSE_WIDTH_TABLE, $urandom);
    send_idle_pct = 54; recv_idle_pct = 36;
    random_phase(330);
    write_reg(mcsg_pkg::REG_CLOCK_MODE, 32'(mcsg_pkg::CLK_MASTER));
    write_reg(mcsg_pkg::REG_TEMPO_PERIOD, 32'd625000000);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(170);
    write_reg(mcsg_pkg::REG_TEMPO_PERIOD, 32'($urandom_range(625000000, 2083333)));
    random_phase(170);
  endtask

  initial begin
    sync_reset();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_master();
    test_random();
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: files.f
sv/mcsg_pkg.sv
sv/mcsg_divcheck.sv
sv/midi_clock_sync_generator.sv
tb/midi_clock_sync_generator_tb.sv
